@@ hw/rtl/button_debounce_and_quadrature_decode_top_macros.svh @@
// Assertion macros for the button debounce and quadrature decode block.
// Used by the top level only; no other dependencies.
`ifndef BUTTON_DEBOUNCE_AND_QUADRATURE_DECODE_TOP_MACROS_SVH
`define BUTTON_DEBOUNCE_AND_QUADRATURE_DECODE_TOP_MACROS_SVH

// same-cycle implication
`define BDQ_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define BDQ_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ hw/rtl/bdq_pkg.sv @@
// Shared types, constants and the Gray-code step table for the debounce/decode block.
// No dependencies.
package bdq_pkg;

   localparam int BUTTON_COUNT = 4;   // lanes, 1..16
   localparam int MASK_W       = 4;   // button bits carried by the ports
   localparam int TIME_W       = 32;
   localparam int DEBOUNCE_W   = 16;
   localparam int DELTA_W      = 16;
   localparam int ACC_W        = 4;
   localparam int CSR_INDEX_W  = 8;
   localparam int CSR_DATA_W   = 16;
   localparam int QUEUE_DEPTH  = 2;

   localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RESET = 16'd20;
   localparam logic [1:0]            LINES_IDLE     = 2'b11;
   localparam logic signed [ACC_W-1:0] STEPS_PER_DETENT = 4'sd4;
   localparam logic signed [DELTA_W-1:0] DELTA_MAX = 16'sh7fff;
   localparam logic signed [DELTA_W-1:0] DELTA_MIN = 16'sh8000;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_DEBOUNCE_MS = 8'd0,
      CSR_DIR_INVERT  = 8'd1
   } csr_index_type;

   // index is {previous lines, current lines}
   localparam logic signed [1:0] GRAY_STEP [16] = '{
       2'sd0, -2'sd1,  2'sd1,  2'sd0,
       2'sd1,  2'sd0,  2'sd0, -2'sd1,
      -2'sd1,  2'sd0,  2'sd0,  2'sd1,
       2'sd0,  2'sd1, -2'sd1,  2'sd0
   };

   typedef struct packed {
      logic pressed;
      logic click;
   } lane_result_type;

   typedef struct packed {
      logic [MASK_W-1:0]         pressed_mask;
      logic [MASK_W-1:0]         click_mask;
      logic signed [DELTA_W-1:0] detent_delta;
   } rsp_word_type;

   typedef struct packed {
      logic       full;
      logic [1:0] count;
   } queue_status_type;

endpackage

@@ hw/rtl/button_debounce_and_quadrature_decode_top.sv @@
// Button debounce and quadrature decode, one sample word per cycle.
// The result word enters the output queue when the sample is accepted.
// Throughput: one word per cycle; a two-entry output queue keeps req_ready high
// while one result waits and drops it when full. Lanes and decoder work combinationally.
// Reset (synchronous): lanes and flags cleared, encoder lines idle high,
// debounce_ms = 20, detent direction not inverted, output queue empty.
`include "button_debounce_and_quadrature_decode_top_macros.svh"
module button_debounce_and_quadrature_decode_top
   import bdq_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [MASK_W-1:0]         req_button_levels,
   input  logic                      req_enc_clk,
   input  logic                      req_enc_dt,
   input  logic [TIME_W-1:0]         req_now_ms,
   input  logic [MASK_W-1:0]         req_clear_click_mask,
   input  logic                      req_take_delta,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [MASK_W-1:0]         rsp_pressed_mask,
   output logic [MASK_W-1:0]         rsp_click_mask,
   output logic signed [DELTA_W-1:0] rsp_detent_delta,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_INDEX_W-1:0]    csr_index,
   input  logic [CSR_DATA_W-1:0]     csr_wdata
);

   logic [DEBOUNCE_W-1:0]     debounce_ms_ff, debounce_ms_in;
   logic                      reversed_ff, reversed_in;
   logic                      req_fire;
   logic                      rsp_fire;
   lane_result_type           lanes [BUTTON_COUNT];
   logic signed [DELTA_W-1:0] detent_delta;
   rsp_word_type              head;
   queue_status_type          status;

   assign csr_ready = 1'b1;
   assign req_ready = ~status.full;
   assign req_fire  = req_valid & req_ready;
   assign rsp_fire  = rsp_valid & rsp_ready;

   always_comb begin
      debounce_ms_in = debounce_ms_ff;
      reversed_in    = reversed_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_DEBOUNCE_MS: debounce_ms_in = csr_wdata;
            CSR_DIR_INVERT:  reversed_in    = csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ms_ff <= DEBOUNCE_RESET;
         reversed_ff    <= 1'b0;
      end else begin
         debounce_ms_ff <= debounce_ms_in;
         reversed_ff    <= reversed_in;
      end
   end

   // buttons past the port width read level 0, i.e. pressed
   for (genvar i = 0; i < BUTTON_COUNT; i++) begin : g_lane
      logic reading;
      logic clear_click;
      if (i < MASK_W) begin : g_port
         assign reading     = ~req_button_levels[i];
         assign clear_click = req_clear_click_mask[i];
      end else begin : g_extra
         assign reading     = 1'b1;
         assign clear_click = 1'b0;
      end
      bdq_button_lane u_lane (
         .clock       (clock),
         .reset       (reset),
         .req_fire    (req_fire),
         .reading     (reading),
         .now_ms      (req_now_ms),
         .debounce_ms (debounce_ms_ff),
         .clear_click (clear_click),
         .result      (lanes[i])
      );
   end

   bdq_encoder u_encoder (
      .clock        (clock),
      .reset        (reset),
      .req_fire     (req_fire),
      .lines        ({req_enc_clk, req_enc_dt}),
      .dir_invert   (reversed_ff),
      .take_delta   (req_take_delta),
      .detent_delta (detent_delta)
   );

   bdq_merge u_merge (
      .clock        (clock),
      .reset        (reset),
      .push         (req_fire),
      .lanes        (lanes),
      .detent_delta (detent_delta),
      .rsp_ready    (rsp_ready),
      .rsp_valid    (rsp_valid),
      .head         (head),
      .status       (status)
   );

   assign rsp_pressed_mask = head.pressed_mask;
   assign rsp_click_mask   = head.click_mask;
   assign rsp_detent_delta = head.detent_delta;

   `BDQ_ASSERT_NOW(a_count_bound, clock, reset, 1'b1,
      status.count <= 2'(QUEUE_DEPTH), "queue overrun")
   `BDQ_ASSERT_NOW(a_valid_count, clock, reset, 1'b1,
      rsp_valid == (status.count != 2'd0), "valid/count mismatch")
   `BDQ_ASSERT_NEXT(a_push_grows, clock, reset, req_fire && !rsp_fire,
      status.count == $past(status.count) + 2'd1, "push lost")
   `BDQ_ASSERT_NEXT(a_pop_shrinks, clock, reset, rsp_fire && !req_fire,
      status.count == $past(status.count) - 2'd1, "pop lost")

endmodule

@@ hw/rtl/bdq_button_lane.sv @@
// One debounce lane: raw level tracking, hold timer compare and sticky click flag.
// Depends on bdq_pkg.
module bdq_button_lane
   import bdq_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_fire,
   input  logic                  reading,
   input  logic [TIME_W-1:0]     now_ms,
   input  logic [DEBOUNCE_W-1:0] debounce_ms,
   input  logic                  clear_click,
   output lane_result_type       result
);

   logic              debounced_ff, debounced_in;
   logic              last_raw_ff, last_raw_in;
   logic [TIME_W-1:0] change_time_ff, change_time_in;
   logic              click_ff, click_in;
   logic [TIME_W-1:0] elapsed;
   logic              held;
   logic              click_now;

   always_comb begin
      last_raw_in    = reading;
      change_time_in = (reading != last_raw_ff) ? now_ms : change_time_ff;
      elapsed        = now_ms - change_time_in;   // wraps modulo 2^32
      held           = elapsed >= {{(TIME_W-DEBOUNCE_W){1'b0}}, debounce_ms};
      debounced_in   = held ? reading : debounced_ff;
      click_now      = click_ff | (held & reading & ~debounced_ff);
      click_in       = click_now & ~clear_click;
      result.pressed = debounced_in;
      result.click   = click_now;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         debounced_ff   <= 1'b0;
         last_raw_ff    <= 1'b0;
         change_time_ff <= '0;
         click_ff       <= 1'b0;
      end else if (req_fire) begin
         debounced_ff   <= debounced_in;
         last_raw_ff    <= last_raw_in;
         change_time_ff <= change_time_in;
         click_ff       <= click_in;
      end
   end

endmodule

@@ hw/rtl/bdq_encoder.sv @@
// Quadrature decoder: Gray-code step table, step accumulator, saturating detent delta.
// Depends on bdq_pkg.
module bdq_encoder
   import bdq_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_fire,
   input  logic [1:0]                lines,
   input  logic                      dir_invert,
   input  logic                      take_delta,
   output logic signed [DELTA_W-1:0] detent_delta
);

   logic [1:0]                lines_ff, lines_in;
   logic signed [ACC_W-1:0]   acc_ff, acc_in;
   logic signed [DELTA_W-1:0] delta_ff, delta_in;
   logic signed [ACC_W-1:0]   acc_sum;
   logic                      up, down;
   logic signed [DELTA_W-1:0] delta_new;

   always_comb begin
      lines_in  = lines;
      acc_sum   = acc_ff + ACC_W'(GRAY_STEP[{lines_ff, lines}]);
      up        = 1'b0;
      down      = 1'b0;
      acc_in    = acc_ff;
      if (lines != lines_ff) begin
         acc_in = acc_sum;
         if (acc_sum >= STEPS_PER_DETENT) begin
            acc_in = '0;
            up     = ~dir_invert;
            down   = dir_invert;
         end else if (acc_sum <= -STEPS_PER_DETENT) begin
            acc_in = '0;
            up     = dir_invert;
            down   = ~dir_invert;
         end
      end
      delta_new = delta_ff;
      if (up && delta_ff != DELTA_MAX) begin
         delta_new = delta_ff + DELTA_W'(1);
      end else if (down && delta_ff != DELTA_MIN) begin
         delta_new = delta_ff - DELTA_W'(1);
      end
      delta_in     = take_delta ? '0 : delta_new;
      detent_delta = delta_new;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lines_ff <= LINES_IDLE;
         acc_ff   <= '0;
         delta_ff <= '0;
      end else if (req_fire) begin
         lines_ff <= lines_in;
         acc_ff   <= acc_in;
         delta_ff <= delta_in;
      end
   end

endmodule

@@ hw/rtl/bdq_merge.sv @@
// Merge stage: packs lane and encoder results into a word and holds it in a
// two-entry output queue. Depends on bdq_pkg.
module bdq_merge
   import bdq_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  lane_result_type           lanes [BUTTON_COUNT],
   input  logic signed [DELTA_W-1:0] detent_delta,
   input  logic                      rsp_ready,
   output logic                      rsp_valid,
   output rsp_word_type              head,
   output queue_status_type          status
);

   rsp_word_type word;
   rsp_word_type entry_ff [QUEUE_DEPTH];
   logic         wr_ptr_ff, wr_ptr_in;
   logic         rd_ptr_ff, rd_ptr_in;
   logic [1:0]   count_ff, count_in;
   logic         pop;

   always_comb begin
      word = '0;
      for (int i = 0; i < MASK_W; i++) begin
         if (i < BUTTON_COUNT) begin
            word.pressed_mask[i] = lanes[i].pressed;
            word.click_mask[i]   = lanes[i].click;
         end
      end
      word.detent_delta = detent_delta;
   end

   assign rsp_valid    = count_ff != 2'd0;
   assign pop          = rsp_valid & rsp_ready;
   assign head         = entry_ff[rd_ptr_ff];
   assign status.full  = count_ff == 2'(QUEUE_DEPTH);
   assign status.count = count_ff;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= word;
      end
   end

endmodule

@@ verif/debounce_decode_checker.sv @@
`timescale 1ns / 1ps
// Checker for the button debounce / quadrature decode block: watches the sample,
// result and register channels, predicts every result word and compares it.
// Depends on bdq_pkg only.
module debounce_decode_checker
   import bdq_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   input  logic                      req_ready,
   input  logic [MASK_W-1:0]         req_button_levels,
   input  logic                      req_enc_clk,
   input  logic                      req_enc_dt,
   input  logic [TIME_W-1:0]         req_now_ms,
   input  logic [MASK_W-1:0]         req_clear_click_mask,
   input  logic                      req_take_delta,
   input  logic                      rsp_valid,
   input  logic                      rsp_ready,
   input  logic [MASK_W-1:0]         rsp_pressed_mask,
   input  logic [MASK_W-1:0]         rsp_click_mask,
   input  logic signed [DELTA_W-1:0] rsp_detent_delta,
   input  logic                      csr_valid,
   input  logic                      csr_ready,
   input  logic [CSR_INDEX_W-1:0]    csr_index,
   input  logic [CSR_DATA_W-1:0]     csr_wdata,
   output int                        mismatches,
   output int                        outstanding
);

   localparam int LANES = (BUTTON_COUNT > 16) ? 16 : BUTTON_COUNT;
   localparam int SHOWN = (LANES < MASK_W) ? LANES : MASK_W;

   logic [DEBOUNCE_W-1:0] hold_ms;
   logic                  reversed;
   logic                  stable_pressed [16];
   logic                  raw_pressed [16];
   logic [TIME_W-1:0]     changed_at [16];
   logic                  click_seen [16];
   logic [1:0]            prev_lines;
   int                    step_sum;
   int                    detents;
   rsp_word_type          expected_words [$];

   // position on the Gray ring 11 -> 01 -> 00 -> 10 -> 11
   function automatic int ring_pos(input logic [1:0] lines);
      case (lines)
         2'b11: return 0;
         2'b01: return 1;
         2'b00: return 2;
         default: return 3;
      endcase
   endfunction

   // one ring position forward is +1, back is -1, a jump of two counts nothing
   function automatic int quad_step(input logic [1:0] prev_l, input logic [1:0] next_l);
      int d;
      d = (ring_pos(next_l) - ring_pos(prev_l) + 4) % 4;
      if (d == 1) return 1;
      if (d == 3) return -1;
      return 0;
   endfunction

   task automatic report(input string msg);
      mismatches++;
      $display("%0t checker: %s", $time, msg);
   endtask

   task automatic count_detent(input int dir);
      detents = detents + dir;
      if (detents > 32767) detents = 32767;
      if (detents < -32768) detents = -32768;
   endtask

   task automatic clear_state();
      hold_ms = DEBOUNCE_RESET;
      reversed = 1'b0;
      for (int i = 0; i < 16; i++) begin
         stable_pressed[i] = 1'b0;
         raw_pressed[i] = 1'b0;
         changed_at[i] = '0;
         click_seen[i] = 1'b0;
      end
      prev_lines = LINES_IDLE;
      step_sum = 0;
      detents = 0;
      expected_words.delete();
   endtask

   task automatic apply_sample(output rsp_word_type word);
      logic              reading;
      logic [TIME_W-1:0] held;
      logic [1:0]        lines;
      for (int i = 0; i < LANES; i++) begin
         // lanes past the port width see level 0, i.e. pressed
         reading = (i < MASK_W) ? ~req_button_levels[i] : 1'b1;
         if (reading != raw_pressed[i]) begin
            raw_pressed[i] = reading;
            changed_at[i] = req_now_ms;
         end
         held = req_now_ms - changed_at[i];
         if (held >= {{(TIME_W-DEBOUNCE_W){1'b0}}, hold_ms} && reading != stable_pressed[i]) begin
            stable_pressed[i] = reading;
            if (reading) click_seen[i] = 1'b1;
         end
      end
      lines = {req_enc_clk, req_enc_dt};
      if (lines != prev_lines) begin
         step_sum = step_sum + quad_step(prev_lines, lines);
         prev_lines = lines;
         if (step_sum >= 4) begin
            count_detent(reversed ? -1 : 1);
            step_sum = 0;
         end else if (step_sum <= -4) begin
            count_detent(reversed ? 1 : -1);
            step_sum = 0;
         end
      end
      word = '0;
      for (int i = 0; i < SHOWN; i++) begin
         word.pressed_mask[i] = stable_pressed[i];
         word.click_mask[i] = click_seen[i];
      end
      word.detent_delta = detents[DELTA_W-1:0];
      // clear and take act after the word is formed
      for (int i = 0; i < SHOWN; i++) begin
         if (req_clear_click_mask[i]) click_seen[i] = 1'b0;
      end
      if (req_take_delta) detents = 0;
   endtask

   always @(posedge clock) begin : monitor
      rsp_word_type want;
      rsp_word_type next_word;
      if (reset) begin
         clear_state();
         mismatches = 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_DEBOUNCE_MS: hold_ms = csr_wdata[DEBOUNCE_W-1:0];
               CSR_DIR_INVERT:  reversed = csr_wdata[0];
               default: ;
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_words.size() == 0) begin
               report($sformatf("result word with nothing expected: pressed %h click %h delta %0d",
                                rsp_pressed_mask, rsp_click_mask, rsp_detent_delta));
            end else begin
               want = expected_words.pop_front();
               if (rsp_pressed_mask !== want.pressed_mask)
                  report($sformatf("pressed_mask got %h want %h",
                                   rsp_pressed_mask, want.pressed_mask));
               if (rsp_click_mask !== want.click_mask)
                  report($sformatf("click_mask got %h want %h",
                                   rsp_click_mask, want.click_mask));
               if (rsp_detent_delta !== want.detent_delta)
                  report($sformatf("detent_delta got %0d want %0d",
                                   rsp_detent_delta, want.detent_delta));
            end
         end
         if (req_valid && req_ready) begin
            apply_sample(next_word);
            expected_words.push_back(next_word);
         end
      end
      outstanding = expected_words.size();
   end

endmodule

@@ verif/button_debounce_and_quadrature_decode_top_tb.sv @@
`timescale 1ns / 1ps
// Testbench top for the button debounce / quadrature decode block: clock, reset,
// sample and register stimulus, result back-pressure and the verdict.
// Depends on bdq_pkg, the block and debounce_decode_checker.
module button_debounce_and_quadrature_decode_top_tb
   import bdq_pkg::*;
();

   localparam int LIMIT_CYCLES = 2_000_000;
   localparam int PHASE_WORDS  = 150;
   localparam int SWEEP_STEPS  = 24;   // clean steps each way, six detents

   logic                      clock = 1'b0;
   logic                      reset;
   logic                      req_valid;
   logic                      req_ready;
   logic [MASK_W-1:0]         req_button_levels;
   logic                      req_enc_clk;
   logic                      req_enc_dt;
   logic [TIME_W-1:0]         req_now_ms;
   logic [MASK_W-1:0]         req_clear_click_mask;
   logic                      req_take_delta;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   logic [MASK_W-1:0]         rsp_pressed_mask;
   logic [MASK_W-1:0]         rsp_click_mask;
   logic signed [DELTA_W-1:0] rsp_detent_delta;
   logic                      csr_valid;
   logic                      csr_ready;
   logic [CSR_INDEX_W-1:0]    csr_index;
   logic [CSR_DATA_W-1:0]     csr_wdata;

   int          mismatches;
   int          pending_words;
   int          sender_idle_pct;
   int          recv_idle_pct = 0;
   logic        pressure_start = 1'b0;
   logic        hold_rsp = 1'b0;

   logic [31:0] cur_time;
   logic [3:0]  cur_levels;
   logic [1:0]  cur_lines;
   int          ring_pos;
   int          spin_dir;
   int          debounce_now;

   button_debounce_and_quadrature_decode_top DUT (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_button_levels    (req_button_levels),
      .req_enc_clk          (req_enc_clk),
      .req_enc_dt           (req_enc_dt),
      .req_now_ms           (req_now_ms),
      .req_clear_click_mask (req_clear_click_mask),
      .req_take_delta       (req_take_delta),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_pressed_mask     (rsp_pressed_mask),
      .rsp_click_mask       (rsp_click_mask),
      .rsp_detent_delta     (rsp_detent_delta),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_index            (csr_index),
      .csr_wdata            (csr_wdata)
   );

   debounce_decode_checker u_checker (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_button_levels    (req_button_levels),
      .req_enc_clk          (req_enc_clk),
      .req_enc_dt           (req_enc_dt),
      .req_now_ms           (req_now_ms),
      .req_clear_click_mask (req_clear_click_mask),
      .req_take_delta       (req_take_delta),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_pressed_mask     (rsp_pressed_mask),
      .rsp_click_mask       (rsp_click_mask),
      .rsp_detent_delta     (rsp_detent_delta),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_index            (csr_index),
      .csr_wdata            (csr_wdata),
      .mismatches           (mismatches),
      .outstanding          (pending_words)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(negedge clock) begin
      rsp_ready <= !hold_rsp && ($urandom_range(99) >= recv_idle_pct);
   end

   // long result hold-off so the output queue fills and req_ready drops
   initial begin
      wait (pressure_start);
      @(posedge clock);
      hold_rsp = 1'b1;
      repeat (80) @(posedge clock);
      hold_rsp = 1'b0;
   end

   initial begin
      repeat (LIMIT_CYCLES) @(posedge clock);
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   function automatic logic [1:0] lines_at(input int pos);
      case (pos)
         0: return 2'b11;
         1: return 2'b01;
         2: return 2'b00;
         default: return 2'b10;
      endcase
   endfunction

   // called at a falling edge, returns at the falling edge after the word is taken
   task automatic push_sample(input logic [3:0] lv, input logic ck, input logic dt,
                              input logic [31:0] tm, input logic [3:0] clr,
                              input logic tk);
      if (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
         while ($urandom_range(99) < sender_idle_pct) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_button_levels <= lv;
      req_enc_clk <= ck;
      req_enc_dt <= dt;
      req_now_ms <= tm;
      req_clear_click_mask <= clr;
      req_take_delta <= tk;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_config(input int deb, input logic rev);
      csr_valid <= 1'b1;
      csr_index <= CSR_DEBOUNCE_MS;
      csr_wdata <= deb[CSR_DATA_W-1:0];
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_index <= CSR_DIR_INVERT;
      csr_wdata <= {{(CSR_DATA_W-1){1'b0}}, rev};
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
      debounce_now = deb;
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (pending_words != 0) @(negedge clock);
      repeat (3) @(negedge clock);
   endtask

   // forced_dir 0 gives a random mix; +1/-1 forces a clean encoder step
   task automatic random_sample(input int forced_dir);
      int         pick;
      logic [1:0] lines;
      logic [3:0] clr;
      logic       tk;
      pick = $urandom_range(99);
      if (pick < 4) cur_time = $urandom;
      else if (pick < 12) cur_time = cur_time + $urandom_range(2 * debounce_now + 3, 0);
      else cur_time = cur_time + $urandom_range(debounce_now / 4 + 2, 0);
      pick = $urandom_range(99);
      if (pick >= 92) cur_levels = 4'($urandom_range(15));
      else if (pick >= 70) cur_levels[$urandom_range(3)] = ~cur_levels[$urandom_range(3)];
      if (forced_dir != 0) begin
         ring_pos = (ring_pos + forced_dir + 4) % 4;
      end else begin
         pick = $urandom_range(99);
         if (pick < 10) spin_dir = -spin_dir;
         if (pick < 65) ring_pos = (ring_pos + spin_dir + 4) % 4;
         else if (pick < 80) ring_pos = ring_pos;
         else if (pick < 90) ring_pos = (ring_pos + 2) % 4;   // both lines flip
         else ring_pos = $urandom_range(3);
      end
      lines = lines_at(ring_pos);
      clr = ($urandom_range(99) < 40) ? 4'($urandom_range(15)) : 4'h0;
      tk = (forced_dir == 0) && ($urandom_range(99) < 8);
      push_sample(cur_levels, lines[1], lines[0], cur_time, clr, tk);
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_button_levels = '1;
      req_enc_clk = 1'b1;
      req_enc_dt = 1'b1;
      req_now_ms = '0;
      req_clear_click_mask = '0;
      req_take_delta = 1'b0;
      csr_valid = 1'b0;
      csr_index = CSR_DEBOUNCE_MS;
      csr_wdata = '0;
      sender_idle_pct = 0;
      debounce_now = 20;
      repeat (10) @(negedge clock);
      reset <= 1'b0;
      write_config(20, 1'b0);

      sender_idle_pct = 6;
      recv_idle_pct <= 61;
      // directed: presses, bounce, clicks, time wrap, encoder steps,
      // invalid jumps, reversal without clearing, take and clear
      push_sample(4'hF, 1'b1, 1'b1, 32'd0,  4'h0, 1'b0);
      push_sample(4'hE, 1'b0, 1'b1, 32'd5,  4'h0, 1'b0);
      push_sample(4'hE, 1'b0, 1'b0, 32'd25, 4'h0, 1'b0);
      push_sample(4'hE, 1'b1, 1'b0, 32'd26, 4'h1, 1'b0);
      push_sample(4'hE, 1'b1, 1'b1, 32'd27, 4'h0, 1'b0);
      push_sample(4'h0, 1'b0, 1'b0, 32'd40, 4'h0, 1'b0);
      push_sample(4'h0, 1'b0, 1'b0, 32'd59, 4'h0, 1'b0);
      push_sample(4'h0, 1'b1, 1'b0, 32'd60, 4'hF, 1'b0);
      push_sample(4'hF, 1'b0, 1'b0, 32'hFFFF_FFF8, 4'h0, 1'b0);
      push_sample(4'hF, 1'b0, 1'b1, 32'h0000_000C, 4'h0, 1'b0);
      push_sample(4'hF, 1'b1, 1'b1, 32'h0000_000D, 4'h0, 1'b0);
      push_sample(4'hF, 1'b1, 1'b0, 32'h0000_000E, 4'h0, 1'b0);
      push_sample(4'hF, 1'b1, 1'b1, 32'h0000_000F, 4'h0, 1'b0);
      push_sample(4'hF, 1'b1, 1'b0, 32'h0000_0010, 4'h0, 1'b0);
      push_sample(4'hF, 1'b0, 1'b0, 32'h0000_0011, 4'h0, 1'b0);
      push_sample(4'h5, 1'b0, 1'b0, 32'h0000_0012, 4'h0, 1'b1);
      push_sample(4'h5, 1'b0, 1'b0, 32'h0000_0040, 4'hF, 1'b1);
      push_sample(4'hA, 1'b1, 1'b1, 32'h0000_0050, 4'h0, 1'b0);
      push_sample(4'hA, 1'b0, 1'b1, 32'h0000_0060, 4'h3, 1'b0);
      push_sample(4'hF, 1'b1, 1'b1, 32'hFFFF_FFFF, 4'hF, 1'b1);

      ring_pos = 0;
      spin_dir = 1;
      cur_levels = 4'hF;
      cur_time = 32'hFFFF_FE00;
      for (int i = 0; i < PHASE_WORDS; i++) begin
         if (i == 60) pressure_start <= 1'b1;
         random_sample(0);
      end
      drain();

      write_config(0, 1'b1);
      sender_idle_pct = 61;
      recv_idle_pct <= 6;
      cur_time = 32'hFFFF_FFC0;
      for (int i = 0; i < PHASE_WORDS; i++) random_sample(0);
      drain();

      write_config(65535, 1'b0);
      sender_idle_pct = 0;
      recv_idle_pct <= 0;
      for (int i = 0; i < PHASE_WORDS; i++) random_sample(0);
      drain();

      // spin one way, take the delta, then spin back
      write_config($urandom_range(50, 1), 1'b1);
      for (int i = 0; i < SWEEP_STEPS; i++) random_sample(1);
      cur_lines = lines_at(ring_pos);
      push_sample(cur_levels, cur_lines[1], cur_lines[0], cur_time, 4'h0, 1'b1);
      for (int i = 0; i < SWEEP_STEPS; i++) random_sample(-1);
      drain();

      if (mismatches == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
+incdir+hw/rtl
hw/rtl/bdq_pkg.sv
hw/rtl/bdq_button_lane.sv
hw/rtl/bdq_encoder.sv
hw/rtl/bdq_merge.sv
hw/rtl/button_debounce_and_quadrature_decode_top.sv
verif/debounce_decode_checker.sv
verif/button_debounce_and_quadrature_decode_top_tb.sv
